/* rtl/core/lpm_pkg.sv */
// Shared types, constants and helpers for the IPv4 longest-prefix-match block.
// No dependencies; every other file of the block but lpm_checker imports this package.
package lpm_pkg;

	localparam int ROUTES        = 128;
	localparam int IDX_W         = $clog2(ROUTES);
	localparam int COUNT_W       = 8;
	localparam int ADDR_W        = 32;
	localparam int PORT_W        = 2;
	localparam int LEN_W         = 6;
	localparam int S_TDATA_W     = 144;
	localparam int M_TDATA_W     = 48;

	localparam logic OP_WRITE    = 1'b0;
	localparam logic OP_LOOKUP   = 1'b1;

	localparam logic [1:0] REG_ROUTE_COUNT = 2'd0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic [PORT_W-1:0] port;
		logic [ADDR_W-1:0] hop;
		logic [ADDR_W-1:0] mask;
		logic [ADDR_W-1:0] prefix;
	} route_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic             wr_en;
		logic             start;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             load;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic busy;
		logic out_free;
	} sts_t;

	function automatic logic [2:0] nibble_ones(input logic [3:0] n);
		logic [2:0] c;
		unique case (n)
			4'h0: c = 3'd0;
			4'h1, 4'h2, 4'h4, 4'h8: c = 3'd1;
			4'h3, 4'h5, 4'h6, 4'h9, 4'hA, 4'hC: c = 3'd2;
			4'h7, 4'hB, 4'hD, 4'hE: c = 3'd3;
			4'hF: c = 3'd4;
			default: c = 3'd0;
		endcase
		return c;
	endfunction

	// Count one bits of a mask: eight nibble lookups, then a short sum.
	function automatic logic [LEN_W-1:0] mask_len(input logic [ADDR_W-1:0] m);
		logic [LEN_W-1:0] sum;
		sum = '0;
		for (int k = 0; k < ADDR_W / 4; k++) begin
			sum = sum + LEN_W'(nibble_ones(m[4*k +: 4]));
		end
		return sum;
	endfunction

endpackage

/* rtl/core/lpm_ctrl.sv */
// Controller for the longest-prefix-match block: accepts requests, sequences
// the table scan and hands the result to the output register. Uses lpm_pkg.
module lpm_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic                          op,
	input  logic [lpm_pkg::COUNT_W-1:0]   route_count,
	input  lpm_pkg::sts_t                 sts,
	output lpm_pkg::cmd_t                 cmd
);
	import lpm_pkg::*;

	state_t              state_q, state_d;
	logic [COUNT_W-1:0]  cnt_q, cnt_d;
	logic [COUNT_W-1:0]  limit;
	logic [COUNT_W-1:0]  cnt_inc;
	logic                accept;

	// Clamp the active count to the table size.
	assign limit   = (route_count > COUNT_W'(ROUTES)) ? COUNT_W'(ROUTES) : route_count;
	assign cnt_inc = cnt_q + COUNT_W'(1);
	assign accept  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && op == OP_LOOKUP) begin
					cnt_d   = '0;
					state_d = (limit == '0) ? ST_DRAIN : ST_SCAN;
				end
			end
			ST_SCAN: begin
				cnt_d = cnt_inc;
				if (cnt_inc == limit) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.busy && sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Ready is high in idle only, so a valid request in idle is taken.
	always_comb begin
		s_tready    = 1'b0;
		cmd         = '0;
		cmd.rd_addr = cnt_q[IDX_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				s_tready  = 1'b1;
				cmd.wr_en = s_tvalid && op == OP_WRITE;
				cmd.start = s_tvalid && op == OP_LOOKUP;
			end
			ST_SCAN: begin
				cmd.rd_en = 1'b1;
			end
			ST_DRAIN: begin
				cmd.load = !sts.busy && sts.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

/* rtl/core/lpm_dp.sv */
// Datapath for the longest-prefix-match block: route memory, match pipeline,
// best-route tracking and output register. Uses lpm_pkg.
module lpm_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lpm_pkg::cmd_t                 cmd,
	input  logic [lpm_pkg::IDX_W-1:0]     wr_index,
	input  lpm_pkg::route_t               wr_route,
	input  logic [lpm_pkg::ADDR_W-1:0]    dest_addr,
	output lpm_pkg::sts_t                 sts,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic                          found,
	output logic [lpm_pkg::ADDR_W-1:0]    next_hop_out,
	output logic [lpm_pkg::PORT_W-1:0]    port_out,
	output logic [lpm_pkg::LEN_W-1:0]     prefix_len,
	output logic [lpm_pkg::IDX_W-1:0]     entry_out
);
	import lpm_pkg::*;

	route_t              mem [ROUTES];
	logic [ADDR_W-1:0]   dest_q;

	route_t              rdata_s1;
	logic                valid_s1;
	logic [IDX_W-1:0]    idx_s1;

	logic                valid_s2;
	logic                hit_s2;
	logic [LEN_W-1:0]    len_s2;
	logic [IDX_W-1:0]    idx_s2;
	logic [ADDR_W-1:0]   hop_s2;
	logic [PORT_W-1:0]   port_s2;

	logic                best_hit_q;
	logic [LEN_W-1:0]    best_len_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic [ADDR_W-1:0]   best_hop_q;
	logic [PORT_W-1:0]   best_port_q;

	logic                out_valid_q;
	logic                take;

	// Route memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_index] <= wr_route;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem[cmd.rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dest_q <= dest_addr;
		end
		idx_s1  <= cmd.rd_addr;
		hit_s2  <= ((dest_q ^ rdata_s1.prefix) & rdata_s1.mask) == '0;
		len_s2  <= mask_len(rdata_s1.mask);
		idx_s2  <= idx_s1;
		hop_s2  <= rdata_s1.hop;
		port_s2 <= rdata_s1.port;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_en;
			valid_s2 <= valid_s1;
		end
	end

	// Keep the longest match; a later entry wins only on a strictly longer mask.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_hit_q <= 1'b0;
		end else if (cmd.start) begin
			best_hit_q <= 1'b0;
		end else if (valid_s2 && hit_s2 && (!best_hit_q || len_s2 > best_len_q)) begin
			best_hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && hit_s2 && (!best_hit_q || len_s2 > best_len_q)) begin
			best_len_q  <= len_s2;
			best_idx_q  <= idx_s2;
			best_hop_q  <= hop_s2;
			best_port_q <= port_s2;
		end
	end

	assign take         = out_valid_q && m_tready;
	assign sts.busy     = valid_s1 || valid_s2;
	assign sts.out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			found        <= best_hit_q;
			next_hop_out <= best_hit_q ? best_hop_q  : '0;
			port_out     <= best_hit_q ? best_port_q : '0;
			prefix_len   <= best_hit_q ? best_len_q  : '0;
			entry_out    <= best_hit_q ? best_idx_q  : '0;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

/* rtl/core/ipv4_longest_prefix_match.sv */
// IPv4 longest-prefix-match route table, top level: stream ports, APB
// register port, controller and datapath. Uses lpm_pkg, lpm_ctrl, lpm_dp.
//
// A write request (s_tuser = 0) stores one route entry and gives no result.
// A lookup request (s_tuser = 1) scans entries 0 up to route_count - 1
// (route_count clamped to 128), one entry per cycle through the single read
// port of the route memory, and returns one result: the matching entry with
// the longest mask, the earlier entry on a tie; a /0 route matches every
// address. Each entry read passes from that memory port through a two-stage
// match pipeline into the best-route registers, and the result is then
// loaded into the output register. Requests are taken one at a time; a
// finished result waits in the output register, so a new request is
// accepted while the previous result is still held. Entries read by a
// lookup must have been written first: there is no clearing pass and no
// valid bit per entry. route_count is written through the APB port at byte
// address 0; the user must do so only while the block is idle, which the
// block itself does not enforce.
module ipv4_longest_prefix_match (
	input  logic         clk,
	input  logic         arst_n,
	// request stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// [6:0] entry_index, [38:7] route_prefix_in, [70:39] route_mask_in,
	// [102:71] next_hop_in, [104:103] port_in, [136:105] dest_addr, rest zero
	input  logic [143:0] s_tdata,
	// [0] op
	input  logic [0:0]   s_tuser,
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] next_hop_out, [33:32] port_out, [39:34] prefix_len,
	// [46:40] entry_out, [47] zero
	output logic [47:0]  m_tdata,
	// [0] found
	output logic [0:0]   m_tuser,
	// register port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [1:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import lpm_pkg::*;

	logic [COUNT_W-1:0] route_count_q;
	cmd_t               cmd;
	sts_t               sts;
	route_t             wr_route;
	logic [IDX_W-1:0]   wr_index;
	logic [ADDR_W-1:0]  dest_addr;
	logic               found;
	logic [ADDR_W-1:0]  next_hop_out;
	logic [PORT_W-1:0]  port_out;
	logic [LEN_W-1:0]   prefix_len;
	logic [IDX_W-1:0]   entry_out;

	// Register port: always ready, single register at address zero.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_count_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr == REG_ROUTE_COUNT) begin
			route_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == REG_ROUTE_COUNT) begin
			prdata = {{(32-COUNT_W){1'b0}}, route_count_q};
		end
	end

	// Unpack the request fields.
	assign wr_index        = s_tdata[6:0];
	assign wr_route.prefix = s_tdata[38:7];
	assign wr_route.mask   = s_tdata[70:39];
	assign wr_route.hop    = s_tdata[102:71];
	assign wr_route.port   = s_tdata[104:103];
	assign dest_addr       = s_tdata[136:105];

	lpm_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.op          (s_tuser[0]),
		.route_count (route_count_q),
		.sts         (sts),
		.cmd         (cmd)
	);

	lpm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.wr_index     (wr_index),
		.wr_route     (wr_route),
		.dest_addr    (dest_addr),
		.sts          (sts),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.found        (found),
		.next_hop_out (next_hop_out),
		.port_out     (port_out),
		.prefix_len   (prefix_len),
		.entry_out    (entry_out)
	);

	// Pack the result fields.
	assign m_tdata = {1'b0, entry_out, prefix_len, port_out, next_hop_out};
	assign m_tuser = found;

endmodule

/* rtl/core/lpm_checker.sv */
// Port-level checks for ipv4_longest_prefix_match, bound to the top level.
// Depends on the top level's port list only.
module lpm_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [0:0]   s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [47:0]  m_tdata,
	input logic [0:0]   m_tuser
);

	// Hold a stalled result steady.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// A miss carries all-zero fields.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 48'd0)
		else $error("miss result has nonzero fields");

	// Prefix length never exceeds an IPv4 address; the top result bit is zero.
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:34] <= 6'd32 && !m_tdata[47])
		else $error("prefix length out of range");

	// Drop ready while a lookup is being scanned.
	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
		else $error("request accepted during a lookup");

endmodule

bind ipv4_longest_prefix_match lpm_checker u_lpm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for ipv4_longest_prefix_match: stream requests in,
// lookup results out, route_count over APB. Depends on lpm_pkg and the RTL only.
module tb_top;
	import lpm_pkg::*;

	localparam int WDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 125;
	localparam int PHASE_ROUTES [8] = '{128, 6, 255, 1, 20, 0, 48, 3};

	typedef enum int {GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH} gap_mode_t;

	typedef struct packed {
		logic              op;
		logic [IDX_W-1:0]  idx;
		logic [ADDR_W-1:0] prefix;
		logic [ADDR_W-1:0] mask;
		logic [ADDR_W-1:0] hop;
		logic [PORT_W-1:0] port;
		logic [ADDR_W-1:0] dest;
	} route_req_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] hop;
		logic [PORT_W-1:0] port;
		logic [LEN_W-1:0]  len;
		logic [IDX_W-1:0]  idx;
	} route_hit_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [0:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [0:0]           m_tuser;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [1:0]           paddr = '0;
	logic [31:0]          pwdata = '0;
	logic [31:0]          prdata;
	logic                 pready;

	// shadow of the route table and the register
	bit [ADDR_W-1:0] tbl_prefix [ROUTES];
	bit [ADDR_W-1:0] tbl_mask [ROUTES];
	bit [ADDR_W-1:0] tbl_hop [ROUTES];
	bit [PORT_W-1:0] tbl_port [ROUTES];
	int              route_cnt = 0;

	route_req_t pending_requests [$];
	route_hit_t expected_hits [$];
	route_req_t cur_req;
	int         err_cnt = 0;
	int         send_pct = 0;
	int         recv_pct = 0;
	logic       hold_arm = 1'b0;
	logic       hold_seen = 1'b0;
	int         hold_left = 0;
	int         quiet_cycles = 0;

	ipv4_longest_prefix_match i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [ADDR_W-1:0] prefix_mask(input int len);
		return (len == 0) ? '0 : (32'hFFFF_FFFF << (ADDR_W - len));
	endfunction

	// Longest match over the active entries; the earlier entry keeps a tie.
	function automatic route_hit_t predict_lookup(input logic [ADDR_W-1:0] dest);
		route_hit_t r;
		int         lim;
		int         len;
		r = '0;
		lim = (route_cnt > ROUTES) ? ROUTES : route_cnt;
		for (int i = 0; i < lim; i++) begin
			if (((dest ^ tbl_prefix[i]) & tbl_mask[i]) == '0) begin
				len = $countones(tbl_mask[i]);
				if (!r.found || len > r.len) begin
					r.found = 1'b1;
					r.len   = LEN_W'(len);
					r.idx   = IDX_W'(i);
					r.hop   = tbl_hop[i];
					r.port  = tbl_port[i];
				end
			end
		end
		return r;
	endfunction

	// Apply one accepted request to the shadow table or queue its lookup result.
	function automatic void commit_request(input route_req_t q);
		if (q.op == OP_WRITE) begin
			tbl_prefix[q.idx] = q.prefix;
			tbl_mask[q.idx]   = q.mask;
			tbl_hop[q.idx]    = q.hop;
			tbl_port[q.idx]   = q.port;
		end else begin
			expected_hits.push_back(predict_lookup(q.dest));
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			err_cnt++;
		end
	endfunction

	// Every field random; the unused fields of each kind stay random on purpose.
	function automatic route_req_t noise_req(input logic op);
		route_req_t q;
		q.op     = op;
		q.idx    = IDX_W'($urandom);
		q.prefix = $urandom;
		q.mask   = $urandom;
		q.hop    = $urandom;
		q.port   = PORT_W'($urandom);
		q.dest   = $urandom;
		return q;
	endfunction

	// Random route: mostly contiguous masks, some nested under existing routes,
	// some exact copies (ties), some /0 and some scattered masks.
	function automatic route_req_t make_write(input int span);
		route_req_t q;
		int         j;
		int         pick;
		q = noise_req(OP_WRITE);
		if (span > 0 && $urandom_range(0, 9) < 7)
			q.idx = IDX_W'($urandom_range(0, span - 1));
		j = $urandom_range(0, (span > 0) ? span - 1 : ROUTES - 1);
		pick = $urandom_range(0, 9);
		if (pick == 2)
			q.mask = '0;
		else if (pick > 2)
			q.mask = prefix_mask($urandom_range(0, ADDR_W));
		if (pick >= 5)
			q.prefix = (tbl_prefix[j] & tbl_mask[j]) | (q.prefix & ~tbl_mask[j]);
		if (pick == 9) begin
			q.prefix = tbl_prefix[j];
			q.mask   = tbl_mask[j];
		end
		return q;
	endfunction

	// Random lookup: mostly aimed at an active route, some one bit off its net.
	function automatic route_req_t make_lookup(input int span);
		route_req_t q;
		int         j;
		q = noise_req(OP_LOOKUP);
		if (span > 0 && $urandom_range(0, 3) != 0) begin
			j = $urandom_range(0, span - 1);
			q.dest = (tbl_prefix[j] & tbl_mask[j]) | (q.dest & ~tbl_mask[j]);
			if ($urandom_range(0, 3) == 0)
				q.dest = q.dest ^ (tbl_mask[j] & -tbl_mask[j]);
		end
		return q;
	endfunction

	function automatic void push_route(input int idx, input logic [ADDR_W-1:0] prefix,
			input logic [ADDR_W-1:0] mask, input logic [ADDR_W-1:0] hop, input int port);
		route_req_t q;
		q        = noise_req(OP_WRITE);
		q.idx    = IDX_W'(idx);
		q.prefix = prefix;
		q.mask   = mask;
		q.hop    = hop;
		q.port   = PORT_W'(port);
		pending_requests.push_back(q);
	endfunction

	function automatic void push_lookup(input logic [ADDR_W-1:0] dest);
		route_req_t q;
		q      = noise_req(OP_LOOKUP);
		q.dest = dest;
		pending_requests.push_back(q);
	endfunction

	// Hold until every request is taken and every result is back, then let
	// a full scan's worth of cycles pass.
	task automatic wait_idle();
		@(negedge clk);
		while (pending_requests.size() != 0 || s_tvalid || expected_hits.size() != 0)
			@(negedge clk);
		repeat (ROUTES + 8) @(negedge clk);
	endtask

	// Write route_count (junk in the upper bits), then read it back.
	task automatic set_route_count(input logic [7:0] cnt);
		logic [31:0] wdata;
		wdata = $urandom;
		wdata[7:0] = cnt;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_ROUTE_COUNT;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		route_cnt = int'(cnt);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		check_field("route_count", 32'(cnt), 32'(prdata[7:0]));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Request driver: advance to the next request only when the current one
	// is taken or none is offered.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				commit_request(cur_req);
			if (!s_tvalid || s_tready) begin
				if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_pct) begin
					cur_req = pending_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {7'b0, cur_req.dest, cur_req.port, cur_req.hop,
						cur_req.mask, cur_req.prefix, cur_req.idx};
					s_tuser  <= cur_req.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, armed once by the sequencer.
	always @(posedge clk) begin
		if (hold_arm && !hold_seen) begin
			hold_left <= HOLD_CYCLES;
			hold_seen <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Result monitor: compare each taken result with the oldest expectation.
	always @(posedge clk) begin
		route_hit_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_hits.size() == 0) begin
					$error("result with no lookup outstanding: tdata 0x%0h", m_tdata);
					err_cnt++;
				end else begin
					want = expected_hits.pop_front();
					check_field("found", 32'(want.found), 32'(m_tuser[0]));
					check_field("next_hop_out", want.hop, m_tdata[31:0]);
					check_field("port_out", 32'(want.port), 32'(m_tdata[33:32]));
					check_field("prefix_len", 32'(want.len), 32'(m_tdata[39:34]));
					check_field("entry_out", 32'(want.idx), 32'(m_tdata[46:40]));
				end
			end
			m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_pct);
		end
	end

	// Watchdog: drop the run after too long with no handshake on either side.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		route_req_t q;
		int         span;
		gap_mode_t  mode;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// route_count is zero after reset: nothing can match
		push_lookup(32'h0000_0000);
		push_lookup(32'hFFFF_FFFF);
		wait_idle();

		// fill the whole table so no lookup ever reads an unwritten slot
		for (int i = 0; i < ROUTES; i++) begin
			q = make_write(ROUTES);
			q.idx = IDX_W'(i);
			pending_requests.push_back(q);
		end

		// hand-built table for the directed lookups
		push_route(0, 32'h0A00_0000, prefix_mask(8), 32'h0A00_00FE, 1);
		push_route(1, 32'h0A01_0000, prefix_mask(16), 32'h0A01_00FE, 2);
		push_route(2, 32'h0A01_FFFF, prefix_mask(16), 32'h0A01_01FE, 3);
		push_route(3, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 0);
		push_route(4, 32'hC0A8_0101, prefix_mask(32), 32'hC0A8_01FE, 3);
		push_route(5, 32'hFFFF_FFFF, prefix_mask(32), 32'h0000_0000, 2);
		push_route(6, 32'h0A0B_0C0D, 32'hF0F0_F0F0, 32'h1234_5678, 1);
		push_route(7, 32'hFFFF_FFFF, 32'h0000_0000, 32'h5A5A_5A5A, 3);
		push_route(ROUTES - 1, 32'h0A01_0200, prefix_mask(24), 32'h0A01_02FE, 3);
		wait_idle();

		// three entries: /16 beats /8, the earlier /16 wins the tie, no default yet
		set_route_count(8'd3);
		push_lookup(32'h0A01_0203);
		push_lookup(32'h0B00_0001);
		push_lookup(32'h0AC8_0001);
		wait_idle();

		// eight entries: default route, host routes, scattered mask
		set_route_count(8'd8);
		push_lookup(32'h0B00_0001);
		push_lookup(32'hC0A8_0101);
		push_lookup(32'hC0A8_0100);
		push_lookup(32'hFFFF_FFFF);
		push_lookup(32'h0F0F_0F0F);
		push_lookup(32'h0000_0000);
		// rewrite a route and look it up right behind the write
		push_route(1, 32'h0A01_0000, prefix_mask(16), 32'h0A01_0AFE, 0);
		push_lookup(32'h0A01_FFFF);

		for (int p = 0; p < 8; p++) begin
			wait_idle();
			set_route_count(8'(PHASE_ROUTES[p]));
			mode = gap_mode_t'(p % 4);
			case (mode)
				GAP_NONE: begin send_pct = 0;  recv_pct = 0;  end
				GAP_SEND: begin send_pct = 63; recv_pct = 0;  end
				GAP_RECV: begin send_pct = 0;  recv_pct = 63; end
				default:  begin send_pct = 29; recv_pct = 29; end
			endcase
			// back up the block: stall the output while requests keep coming
			if (p == 4)
				hold_arm = 1'b1;
			span = (PHASE_ROUTES[p] > ROUTES) ? ROUTES : PHASE_ROUTES[p];
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 9) < 4)
					pending_requests.push_back(make_write(span));
				else
					pending_requests.push_back(make_lookup(span));
			end
		end
		wait_idle();

		if (err_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
